// ----- hw/rtl/wtp_pkg.sv -----
package wtp_pkg;

   // default sizes
   localparam int DEF_NUM_SPECIES    = 256;
   localparam int DEF_NUM_COMPONENTS = 16;
   localparam int MAX_EMIT           = 16;

   // field and datapath widths
   localparam int SPECIES_W = 8;
   localparam int IDX_W     = 4;
   localparam int AB_W      = 16;
   localparam int COEF_W    = 32;
   localparam int TOT_W     = 24;
   localparam int PROD_W    = AB_W + 1 + COEF_W;   // signed product, Q24.24
   localparam int SUM_W     = 56;                  // saturating sum, Q31.24
   localparam int CUM_W     = COEF_W + 5;          // running offset sum over 16 comps
   localparam int LIN_W     = SUM_W - 8 + 2;       // rounded sum plus mean
   localparam int DIFF_W    = LIN_W + 1;
   localparam int QUO_W     = 32;
   localparam int CNT_W     = 5;
   localparam int COUNT_W   = 5;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic MODE_WA = 1'b1;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_COEF   = 2'd1,
      OP_OFFSET = 2'd2
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE       = 2'd0,
      CSR_MEAN_Y     = 2'd1,
      CSR_COMP_COUNT = 2'd2
   } csr_addr_type;

   // controls broadcast along the cell row
   typedef struct packed {
      logic             rd_en;
      logic             coef_we;
      logic             off_we;
      logic [IDX_W-1:0] comp;
      logic             acc;
      logic             cap;
      logic             shift;
   } cell_ctrl_type;

   // settings seen by the finishing unit
   typedef struct packed {
      logic                     mode;
      logic signed [COEF_W-1:0] mean_y;
      logic [IDX_W-1:0]         nlast;
   } fin_cfg_type;

   typedef struct packed {
      logic busy;
      logic shift;
   } fin_status_type;

endpackage

// ----- hw/rtl/wtp_ram.sv -----
module wtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/wtp_cell.sv -----
module wtp_cell import wtp_pkg::*; #(
   parameter int NUM_SPECIES = DEF_NUM_SPECIES,
   parameter int INDEX = 0,
   localparam int AW = $clog2(NUM_SPECIES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic [AW-1:0]            addr,
   input  logic signed [COEF_W-1:0] wr_coef,
   input  logic [AB_W-1:0]          ab,
   input  logic signed [SUM_W-1:0]  nb_sum,
   input  logic signed [COEF_W-1:0] nb_off,
   output logic signed [SUM_W-1:0]  chain_sum,
   output logic signed [COEF_W-1:0] chain_off
);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   logic                     hit;
   logic [COEF_W-1:0]        coef_rd;
   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] p_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_upd;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  chain_sum_ff;
   logic signed [COEF_W-1:0] chain_off_ff;
   logic signed [COEF_W-1:0] off_ff;

   assign hit = (ctrl.comp == IDX_W'(INDEX));

   // coefficients of this component, one per species
   wtp_ram #(
      .WIDTH (COEF_W),
      .DEPTH (NUM_SPECIES)
   ) u_coef (
      .clock   (clock),
      .wr_en   (ctrl.coef_we & hit),
      .wr_addr (addr),
      .wr_data (wr_coef),
      .rd_en   (ctrl.rd_en),
      .rd_addr (addr),
      .rd_data (coef_rd)
   );

   assign p_in     = $signed({1'b0, ab}) * $signed(coef_rd);
   assign sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(p_ff);

   always_comb begin
      sum_upd = sum_ff;
      if (ctrl.acc) begin
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_upd = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
         end else begin
            sum_upd = sum_wide[SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.cap) begin
         sum_ff <= '0;
      end else if (ctrl.acc) begin
         sum_ff <= sum_upd;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (ctrl.off_we && hit) begin
         off_ff <= wr_coef;
      end
      if (ctrl.cap) begin
         chain_sum_ff <= sum_upd;
         chain_off_ff <= off_ff;
      end else if (ctrl.shift) begin
         chain_sum_ff <= nb_sum;
         chain_off_ff <= nb_off;
      end
   end

   assign chain_sum = chain_sum_ff;
   assign chain_off = chain_off_ff;

endmodule

// ----- hw/rtl/wtp_finish.sv -----
module wtp_finish import wtp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [TOT_W-1:0]         total,
   input  fin_cfg_type              cfg,
   input  logic signed [SUM_W-1:0]  head_sum,
   input  logic signed [COEF_W-1:0] head_off,
   output fin_status_type           status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_idx,
   output logic [COEF_W-1:0]        rsp_est,
   output logic                     rsp_miss,
   output logic                     rsp_last
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_TAKE = 4'b0010,
      F_DIV  = 4'b0100,
      F_FIN  = 4'b1000
   } fin_state_type;

   localparam logic [QUO_W:0] Q_LIMIT = {2'b01, {(QUO_W-1){1'b0}}};

   fin_state_type st_ff, st_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [TOT_W-1:0]         tot_ff, tot_in;
   logic                     neg_ff, neg_in;
   logic                     sat_ff, sat_in;
   logic [TOT_W-1:0]         rem_ff, rem_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [CUM_W-1:0]  cum_ff, cum_in;
   logic signed [LIN_W-1:0]  lin_ff, lin_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_idx_ff;
   logic [COEF_W-1:0]        rsp_est_ff;
   logic                     rsp_miss_ff;
   logic                     rsp_last_ff;
   logic                     load_out;
   logic                     shift;

   logic [SUM_W-1:0]         mag;
   logic                     sat_now;
   logic signed [SUM_W:0]    rnd_wide;
   logic signed [SUM_W-8:0]  rnd;
   logic [TOT_W:0]           trial;
   logic                     ge;
   logic [QUO_W:0]           qc;
   logic [COEF_W-1:0]        wa_est;
   logic signed [DIFF_W-1:0] diff;
   logic [COEF_W-1:0]        lin_est;
   logic [COEF_W-1:0]        est;
   logic                     miss;

   // take the head of the chain apart: magnitude for division, rounding for linear
   assign mag      = head_sum[SUM_W-1] ? (SUM_W'(~head_sum) + SUM_W'(1)) : head_sum;
   assign sat_now  = (mag[SUM_W-1:QUO_W] >= tot_ff);
   assign rnd_wide = (SUM_W+1)'(head_sum) + (SUM_W+1)'(128);
   assign rnd      = rnd_wide[SUM_W:8];

   // one restoring step
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign ge    = (trial >= {1'b0, tot_ff});

   // weighted result, quotient clamped to 2^31 then signed
   always_comb begin
      if (sat_ff || (quo_ff > Q_LIMIT[QUO_W-1:0])) begin
         qc = Q_LIMIT;
      end else begin
         qc = {1'b0, quo_ff};
      end
      if (neg_ff) begin
         wa_est = COEF_W'((QUO_W+1)'(0) - qc);
      end else if (qc[QUO_W-1]) begin
         wa_est = {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
         wa_est = qc[COEF_W-1:0];
      end
   end

   // linear result, clamped to 32 bits
   assign diff = DIFF_W'(lin_ff) - DIFF_W'(cum_ff);
   always_comb begin
      if (diff[DIFF_W-1:COEF_W-1] == '0 || diff[DIFF_W-1:COEF_W-1] == '1) begin
         lin_est = diff[COEF_W-1:0];
      end else if (diff[DIFF_W-1]) begin
         lin_est = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
         lin_est = {1'b0, {(COEF_W-1){1'b1}}};
      end
   end

   always_comb begin
      miss = 1'b0;
      if (cfg.mode == MODE_WA) begin
         miss = (tot_ff == '0);
         est  = miss ? '0 : wa_est;
      end else begin
         est = lin_est;
      end
   end

   always_comb begin
      st_in        = st_ff;
      idx_in       = idx_ff;
      tot_in       = tot_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      cum_in       = cum_ff;
      lin_in       = lin_ff;
      shift        = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (st_ff)
         F_IDLE: begin
            if (start) begin
               tot_in = total;
               idx_in = '0;
               cum_in = '0;
               st_in  = F_TAKE;
            end
         end
         F_TAKE: begin
            neg_in = head_sum[SUM_W-1];
            sat_in = sat_now;
            rem_in = mag[SUM_W-1:QUO_W];
            quo_in = mag[QUO_W-1:0];
            cnt_in = '0;
            cum_in = cum_ff + CUM_W'(head_off);
            lin_in = LIN_W'(rnd) + LIN_W'(cfg.mean_y);
            shift  = 1'b1;
            if (cfg.mode == MODE_WA && tot_ff != '0 && !sat_now) begin
               st_in = F_DIV;
            end else begin
               st_in = F_FIN;
            end
         end
         F_DIV: begin
            rem_in = ge ? TOT_W'(trial - {1'b0, tot_ff}) : trial[TOT_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               st_in = F_FIN;
            end
         end
         F_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               if (idx_ff == cfg.nlast) begin
                  st_in = F_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  st_in  = F_TAKE;
               end
            end
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= F_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tot_ff <= tot_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      cum_ff <= cum_in;
      lin_ff <= lin_in;
      if (load_out) begin
         rsp_idx_ff  <= idx_ff;
         rsp_est_ff  <= est;
         rsp_miss_ff <= miss;
         rsp_last_ff <= (idx_ff == cfg.nlast);
      end
   end

   assign status.busy  = (st_ff != F_IDLE);
   assign status.shift = shift;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_idx      = rsp_idx_ff;
   assign rsp_est      = rsp_est_ff;
   assign rsp_miss     = rsp_miss_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ----- hw/rtl/wapls_transfer_predict.sv -----
// PLS transfer-function predictor. Load transfers (tuser = coefficient or
// offset) fill the per-species coefficient memories and the offset registers;
// sample transfers stream one unsigned Q8.8 abundance per species and tlast
// closes the sample, after which one signed Q16.16 estimate per component is
// sent, tlast on the final one and tuser set when the weighted-mode total was
// zero. There is one cell per component (up to 16), each with its own
// coefficient memory and saturating 56-bit sum; all cells update in parallel.
// Sample and load transfers are taken one per cycle while req_tready is high; a sample's
// close flows through a 3-stage read/multiply/accumulate pipeline, then the sums shift
// out of the cell row into one finishing unit, during which no transfer is taken. For
// each component that unit passes a take state and a finish state, the finish state
// holding until the output register is free; in weighted mode its bit-serial divider
// runs between them unless the total is zero or the quotient saturates. Reads of
// coefficients, marks or offsets that were never written return undefined data.
module wapls_transfer_predict import wtp_pkg::*; #(
   parameter int NUM_SPECIES    = DEF_NUM_SPECIES,
   parameter int NUM_COMPONENTS = DEF_NUM_COMPONENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   // species[7:0], component[11:8], abundance[27:12], coefficient[59:28],
   // coef_missing[60], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // component_index[3:0], estimate[35:4], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // estimate_missing[0]
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CELLS = (NUM_COMPONENTS < MAX_EMIT) ? NUM_COMPONENTS : MAX_EMIT;
   localparam int AW    = $clog2(NUM_SPECIES);
   localparam int SPW   = (AW >= SPECIES_W) ? AW + 1 : SPECIES_W + 1;

   // transfer fields
   logic [SPECIES_W-1:0]     species;
   logic [IDX_W-1:0]         component;
   logic [AB_W-1:0]          abundance;
   logic signed [COEF_W-1:0] coefficient;
   logic                     coef_missing;
   op_type                   op;

   // settings
   logic                     mode_ff;
   logic signed [COEF_W-1:0] mean_y_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic [IDX_W-1:0]         nlast;

   logic                     accept;
   logic                     is_sample, is_coef, is_off;
   logic [SPW-1:0]           sp_ext;
   logic                     sp_ok;
   logic [AW-1:0]            addr;
   logic                     miss_rd;

   // pipeline: stage 1 = memory read, stage 2 = multiply, then accumulate
   logic                     s1_v_ff;
   logic                     s1_last_ff;
   logic                     s1_ok_ff;
   logic [AB_W-1:0]          s1_ab_ff;
   logic                     s2_acc_ff;
   logic                     s2_last_ff;
   logic [AB_W-1:0]          s2_ab_ff;

   logic [TOT_W-1:0]         total_ff;
   logic [TOT_W-1:0]         total_upd;
   logic [TOT_W:0]           total_wide;

   cell_ctrl_type            ctrl;
   fin_cfg_type              fin_cfg;
   fin_status_type           fin_status;
   logic signed [COEF_W-1:0] wr_coef;

   logic signed [SUM_W-1:0]  cell_sum [CELLS];
   logic signed [COEF_W-1:0] cell_off [CELLS];

   logic [IDX_W-1:0]         rsp_idx;
   logic [COEF_W-1:0]        rsp_est;
   logic                     rsp_miss;

   assign species      = req_tdata[7:0];
   assign component    = req_tdata[11:8];
   assign abundance    = req_tdata[27:12];
   assign coefficient  = req_tdata[59:28];
   assign coef_missing = req_tdata[60];
   assign op           = op_type'(req_tuser);

   // a close in flight or a drain in progress holds off new transfers
   assign req_tready = ~(s1_v_ff & s1_last_ff) & ~s2_last_ff & ~fin_status.busy;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      is_sample = 1'b0;
      is_coef   = 1'b0;
      is_off    = 1'b0;
      case (op)
         OP_SAMPLE: is_sample = accept;
         OP_COEF:   is_coef   = accept;
         OP_OFFSET: is_off    = accept;
         default: ;
      endcase
   end

   assign sp_ext  = SPW'(species);
   assign sp_ok   = (sp_ext < SPW'(NUM_SPECIES));
   assign addr    = sp_ext[AW-1:0];
   // a missing coefficient is stored as zero; offsets keep their value
   assign wr_coef = (coef_missing && op == OP_COEF) ? '0 : coefficient;

   // per-species missing marks, written by component 0 loads only
   wtp_ram #(
      .WIDTH (1),
      .DEPTH (NUM_SPECIES)
   ) u_miss (
      .clock   (clock),
      .wr_en   (is_coef & sp_ok & (component == '0)),
      .wr_addr (addr),
      .wr_data (coef_missing),
      .rd_en   (is_sample),
      .rd_addr (addr),
      .rd_data (miss_rd)
   );

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_WA;
         mean_y_ff <= '0;
         count_ff  <= COUNT_W'(1);
      end else if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_MODE:       mode_ff   <= csr_wdata[0];
            CSR_MEAN_Y:     mean_y_ff <= csr_wdata;
            CSR_COMP_COUNT: count_ff  <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // emitted count clamped to 1..CELLS, kept as last index
   always_comb begin
      if (count_ff == '0) begin
         nlast = '0;
      end else if (count_ff > COUNT_W'(CELLS)) begin
         nlast = IDX_W'(CELLS - 1);
      end else begin
         nlast = IDX_W'(count_ff - COUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_acc_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
      end else begin
         s1_v_ff    <= is_sample;
         s2_acc_ff  <= s1_v_ff & s1_ok_ff & ~miss_rd;
         s2_last_ff <= s1_v_ff & s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (is_sample) begin
         s1_last_ff <= req_tlast;
         s1_ok_ff   <= sp_ok;
         s1_ab_ff   <= abundance;
      end
      s2_ab_ff <= s1_ab_ff;
   end

   // abundance total, saturating at full scale
   assign total_wide = {1'b0, total_ff} + (TOT_W+1)'(s2_ab_ff);
   always_comb begin
      total_upd = total_ff;
      if (s2_acc_ff) begin
         total_upd = total_wide[TOT_W] ? '1 : total_wide[TOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (s2_last_ff) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_upd;
      end
   end

   assign ctrl.rd_en   = is_sample;
   assign ctrl.coef_we = is_coef & sp_ok;
   assign ctrl.off_we  = is_off;
   assign ctrl.comp    = component;
   assign ctrl.acc     = s2_acc_ff;
   assign ctrl.cap     = s2_last_ff;
   assign ctrl.shift   = fin_status.shift;

   // cell row; sums leave through cell 0
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      logic signed [SUM_W-1:0]  nb_sum;
      logic signed [COEF_W-1:0] nb_off;
      if (k == CELLS - 1) begin : g_end
         assign nb_sum = '0;
         assign nb_off = '0;
      end else begin : g_mid
         assign nb_sum = cell_sum[k+1];
         assign nb_off = cell_off[k+1];
      end
      wtp_cell #(
         .NUM_SPECIES (NUM_SPECIES),
         .INDEX       (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .addr      (addr),
         .wr_coef   (wr_coef),
         .ab        (s1_ab_ff),
         .nb_sum    (nb_sum),
         .nb_off    (nb_off),
         .chain_sum (cell_sum[k]),
         .chain_off (cell_off[k])
      );
   end

   assign fin_cfg.mode   = mode_ff;
   assign fin_cfg.mean_y = mean_y_ff;
   assign fin_cfg.nlast  = nlast;

   wtp_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .start     (s2_last_ff),
      .total     (total_upd),
      .cfg       (fin_cfg),
      .head_sum  (cell_sum[0]),
      .head_off  (cell_off[0]),
      .status    (fin_status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_idx   (rsp_idx),
      .rsp_est   (rsp_est),
      .rsp_miss  (rsp_miss),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - COEF_W - IDX_W)'(0), rsp_est, rsp_idx};
   assign rsp_tuser = rsp_miss;

`ifndef SYNTH
   // a sample close must never find the finishing unit still draining
   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      s2_last_ff |-> !fin_status.busy)
      else $error("sample close while drain in progress");

   // the final estimate of a run carries the clamped last index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3:0] == nlast)
      else $error("run closed at wrong component");

   // a missing estimate is zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[35:4] == '0)
      else $error("missing estimate not zero");
`endif

endmodule

// ----- tb/wapls_transfer_predict_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the PLS transfer-function predictor.
// Load transfers fill a local copy of the coefficient, mark and offset tables,
// sample transfers accumulate into local sums, and each closing transfer
// queues the estimates the block must send. A checker pops one estimate per
// response transfer and compares all fields.
module wapls_transfer_predict_tb import wtp_pkg::*; ();

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int TOTAL_ITEMS   = 410;
   localparam int SETTLE_CYCLES = 20;   // room for loads still in the pipe
   localparam int TAIL_CYCLES   = 200;
   localparam int REPORT_MAX    = 10;
   localparam int SAT_RUN       = 260;  // enough full-scale items to clip sum and total

   localparam logic [1:0] OP_RESERVED = 2'd3;   // no operation, must be dropped

   localparam longint SUM_TOP    = (64'sd1 <<< 55) - 1;
   localparam longint SUM_BOTTOM = -(64'sd1 <<< 55);
   localparam longint TOTAL_TOP  = 64'sd16777215;
   localparam longint EST_TOP    = 64'sd2147483647;
   localparam longint EST_BOTTOM = -64'sd2147483648;
   localparam longint QUO_CAP    = 64'sd2147483648;

   typedef struct packed {
      logic [3:0]  comp;
      logic [31:0] value;
      logic        missing;
      logic        last;
   } estimate_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = OP_SAMPLE;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Local copy of the block's tables, sums and settings
   logic signed [31:0] coef_mem   [256][16];
   bit                 coef_known [256][16];
   bit                 mark_mem   [256];
   bit                 mark_known [256];
   logic signed [31:0] offset_mem [16];
   longint             comp_sum   [16];
   longint             abund_total = 0;
   logic               cfg_mode = MODE_WA;
   logic signed [31:0] cfg_mean_y = 0;
   logic [4:0]         cfg_count = 5'd1;

   estimate_type pending_estimates[$];
   logic [7:0]   species_pool[$];   // species loaded on purpose, candidates for samples
   bit           in_pool [256];

   int req_idle_max = 14;
   int rsp_idle_max = 14;
   int mismatches = 0;
   int transfers_sent = 0;
   int samples_closed = 0;
   int estimates_checked = 0;
   int cycle_count = 0;

   wapls_transfer_predict dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic longint clamp(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic int draw_wait(int max_wait);
      return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
   endfunction

   // Queue one estimate per emitted component, then clear the accumulators.
   function automatic void close_sample();
      longint       cum, s, mag, q, est;
      int           n;
      estimate_type e;
      n = (cfg_count < 1) ? 1 : ((cfg_count > 16) ? 16 : int'(cfg_count));
      cum = 0;
      for (int i = 0; i < n; i++) begin
         cum += longint'(offset_mem[i]);
         s = comp_sum[i];
         est = 0;
         e.missing = 1'b0;
         if (cfg_mode == MODE_WA) begin
            if (abund_total == 0) begin
               e.missing = 1'b1;
            end else begin
               // truncate toward zero, magnitude capped at 2^31
               mag = (s < 0) ? -s : s;
               q = mag / abund_total;
               if (q > QUO_CAP) q = QUO_CAP;
               est = (s < 0) ? -q : q;
            end
         end else begin
            // Q31.24 to Q16.16 rounding half up, then mean and running offset
            est = ((s + 128) >>> 8) + longint'(cfg_mean_y) - cum;
         end
         est = clamp(est, EST_BOTTOM, EST_TOP);
         e.comp = 4'(i);
         e.value = est[31:0];
         e.last = (i == n - 1);
         pending_estimates.push_back(e);
      end
      foreach (comp_sum[i]) comp_sum[i] = 0;
      abund_total = 0;
      samples_closed++;
   endfunction

   function automatic void predict_transfer(logic [1:0] op, logic [7:0] sp, logic [3:0] comp,
                                            logic [15:0] ab, logic signed [31:0] coef,
                                            logic miss, logic last);
      longint prod;
      case (op)
         OP_COEF: begin
            coef_mem[sp][comp] = miss ? 32'sd0 : coef;
            coef_known[sp][comp] = 1'b1;
            // only the component-0 load owns the species mark
            if (comp == 0) begin
               mark_mem[sp] = miss;
               mark_known[sp] = 1'b1;
            end
         end
         OP_OFFSET: offset_mem[comp] = coef;
         OP_SAMPLE: begin
            if (!mark_mem[sp]) begin
               abund_total = clamp(abund_total + longint'(ab), 0, TOTAL_TOP);
               for (int c = 0; c < 16; c++) begin
                  prod = longint'(ab) * longint'(coef_mem[sp][c]);
                  comp_sum[c] = clamp(comp_sum[c] + prod, SUM_BOTTOM, SUM_TOP);
               end
            end
            if (last) close_sample();
         end
         default: ;   // reserved op: dropped
      endcase
   endfunction

   // A sample may only touch species whose mark, and coefficients if not
   // marked, have been written.
   function automatic bit species_usable(logic [7:0] sp);
      if (!mark_known[sp]) return 1'b0;
      if (mark_mem[sp]) return 1'b1;
      for (int c = 0; c < 16; c++)
         if (!coef_known[sp][c]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_species();
      logic [7:0] sp;
      repeat (16) begin
         sp = species_pool[$urandom_range(0, species_pool.size() - 1)];
         if (species_usable(sp)) return sp;
      end
      return 8'd0;   // species 0 is fully loaded up front
   endfunction

   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_abundance();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(1, 16'h0400));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // One input transfer: random gap, then hold until accepted.
   task automatic send_transfer(logic [1:0] op, logic [7:0] sp, logic [3:0] comp,
                                logic [15:0] ab, logic [31:0] coef, logic miss, logic last);
      int gap;
      gap = draw_wait(req_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, miss, coef, ab, comp, sp};
      req_tuser <= op;
      req_tlast <= last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predict_transfer(op, sp, comp, ab, coef, miss, last);
      transfers_sent++;
   endtask

   task automatic send_sample(logic [7:0] sp, logic [15:0] ab, logic last);
      send_transfer(OP_SAMPLE, sp, 4'($urandom_range(0, 15)), ab, $urandom,
                    1'($urandom_range(0, 1)), last);
   endtask

   // Stop sending until every queued estimate is back, then let loads settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_addr_type addr, logic [31:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         CSR_MODE:       cfg_mode = value[0];
         CSR_MEAN_Y:     cfg_mean_y = value;
         CSR_COMP_COUNT: cfg_count = value[4:0];
         default: ;
      endcase
   endtask

   task automatic add_to_pool(logic [7:0] sp);
      if (!in_pool[sp]) begin
         in_pool[sp] = 1'b1;
         species_pool.push_back(sp);
      end
   endtask

   // Full 16-component load; some non-zero components come in missing.
   task automatic load_species(logic [7:0] sp, logic mark);
      for (int c = 0; c < 16; c++)
         send_transfer(OP_COEF, sp, 4'(c), 16'($urandom_range(0, 16'hFFFF)), pick_q16(),
                       (c == 0) ? mark : 1'($urandom_range(0, 11) == 0),
                       1'($urandom_range(0, 1)));
      add_to_pool(sp);
   endtask

   // Response side: random stall per transfer, compare with oldest estimate.
   initial begin : estimate_checker
      estimate_type want, got;
      int           stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_idle_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         got.comp = rsp_tdata[3:0];
         got.value = rsp_tdata[35:4];
         got.missing = rsp_tuser[0];
         got.last = rsp_tlast;
         if (pending_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected estimate: comp %0d est %h missing %0b last %0b",
                        $time, got.comp, got.value, got.missing, got.last);
         end else begin
            want = pending_estimates.pop_front();
            estimates_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"%0t: estimate mismatch: expected comp %0d est %h missing %0b ",
                            "last %0b, got comp %0d est %h missing %0b last %0b"},
                           $time, want.comp, want.value, want.missing, want.last,
                           got.comp, got.value, got.missing, got.last);
            end
         end
      end
   end

   // Offsets at both extremes, species 0 unmarked with random values, species 255 with
   // extreme and missing coefficients, species 0xAA marked missing.
   task automatic test_table_setup();
      for (int c = 0; c < 16; c++)
         send_transfer(OP_OFFSET, 8'($urandom_range(0, 255)), 4'(c),
                       16'($urandom_range(0, 16'hFFFF)),
                       (c == 0) ? 32'h7FFF_FFFF : ((c == 1) ? 32'h8000_0000 : pick_q16()),
                       1'($urandom_range(0, 1)), 1'b0);
      load_species(8'd0, 1'b0);
      for (int c = 0; c < 16; c++)
         send_transfer(OP_COEF, 8'd255, 4'(c), 16'hFFFF,
                       (c == 0) ? 32'h7FFF_FFFF : ((c == 1) ? 32'h8000_0000 : pick_q16()),
                       (c == 2), 1'b0);
      add_to_pool(8'd255);
      send_transfer(OP_COEF, 8'hAA, 4'd0, 16'h0000, $urandom, 1'b1, 1'b0);
      add_to_pool(8'hAA);
   endtask

   // Reset settings first: weighted mode, one estimate per sample; then all sixteen components.
   task automatic test_weighted_defaults();
      send_sample(8'd0, 16'h0100, 1'b1);
      send_sample(8'd255, 16'hFFFF, 1'b1);
      wait_drained();
      write_reg(CSR_COMP_COUNT, 32'd16);
      // full-scale quotient on both signs
      send_sample(8'd255, 16'hFFFF, 1'b1);
   endtask

   // Zero total: all species skipped, or a zero abundance.
   task automatic test_zero_total();
      send_sample(8'hAA, 16'h1234, 1'b1);
      send_sample(8'd0, 16'h0000, 1'b1);
   endtask

   // Reserved op and tlast on loads must not close a sample.
   task automatic test_ignored_items();
      send_transfer(OP_RESERVED, 8'd0, 4'd0, 16'hFFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);
      send_transfer(OP_COEF, 8'h55, 4'd5, 16'h5555, 32'h5555_5555, 1'b0, 1'b1);
      send_transfer(OP_OFFSET, 8'h55, 4'd15, 16'hAAAA, pick_q16(), 1'b1, 1'b1);
      send_sample(8'd0, 16'h0080, 1'b1);
   endtask

   // Linear mode at both mean extremes and both ends of the count clamp.
   task automatic test_linear_mode();
      wait_drained();
      write_reg(CSR_MODE, 32'd0);
      write_reg(CSR_MEAN_Y, 32'h7FFF_FFFF);
      send_sample(8'd255, 16'h0100, 1'b0);
      send_sample(8'd0, 16'hFFFF, 1'b1);
      wait_drained();
      write_reg(CSR_MEAN_Y, 32'h8000_0000);
      send_sample(8'd255, 16'h0100, 1'b1);
      wait_drained();
      write_reg(CSR_COMP_COUNT, 32'd0);   // clamps up to one
      send_sample(8'd0, 16'h0001, 1'b1);
      wait_drained();
      write_reg(CSR_COMP_COUNT, 32'd31);  // clamps down to sixteen
      send_sample(8'd0, pick_abundance(), 1'b1);
   endtask

   // Loads inside an open sample act at once; the running sums are kept.
   task automatic test_load_mid_sample();
      send_sample(8'd0, pick_abundance(), 1'b0);
      send_transfer(OP_COEF, 8'd0, 4'd3, 16'h0000, pick_q16(), 1'b0, 1'b0);
      send_transfer(OP_OFFSET, 8'd0, 4'd7, 16'h0000, pick_q16(), 1'b0, 1'b0);
      send_transfer(OP_COEF, 8'd0, 4'd0, 16'h0000, pick_q16(), 1'b1, 1'b0);
      send_sample(8'd0, 16'hFFFF, 1'b0);   // now skipped
      send_transfer(OP_COEF, 8'd0, 4'd0, 16'h0000, pick_q16(), 1'b0, 1'b0);
      send_sample(8'd0, pick_abundance(), 1'b0);
      send_sample(8'd255, pick_abundance(), 1'b1);
   endtask

   // Long full-scale sample: sums clip at 56 bits, total at 24 bits.
   task automatic test_sum_saturation();
      wait_drained();
      write_reg(CSR_MODE, 32'(MODE_WA));
      write_reg(CSR_COMP_COUNT, 32'd16);
      req_idle_max = 0;
      for (int k = 1; k <= SAT_RUN; k++)
         send_sample(8'd255, 16'hFFFF, k == SAT_RUN);
      req_idle_max = 14;
   endtask

   // Phases of random settings; each phase may load a species, then streams
   // well-formed samples with stray loads and reserved ops mixed in.
   task automatic test_random();
      int items, len;
      bit first_phase;
      items = transfers_sent;
      first_phase = 1'b1;
      while (items < TOTAL_ITEMS) begin
         wait_drained();
         write_reg(CSR_MODE, 32'($urandom_range(0, 1)));
         write_reg(CSR_MEAN_Y, pick_q16());
         write_reg(CSR_COMP_COUNT, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                                : $urandom_range(1, 16));
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         if (first_phase || $urandom_range(0, 1) == 0) begin
            load_species(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
            items += 16;
         end
         first_phase = 1'b0;
         repeat ($urandom_range(5, 10)) begin
            len = $urandom_range(1, 8);
            for (int k = 1; k <= len; k++) begin
               case ($urandom_range(0, 15))
                  0: send_transfer(OP_RESERVED, 8'($urandom_range(0, 255)),
                                   4'($urandom_range(0, 15)),
                                   16'($urandom_range(0, 16'hFFFF)), $urandom,
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  1: begin
                     send_transfer($urandom_range(0, 1) ? OP_COEF : OP_OFFSET,
                                   8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                   16'($urandom_range(0, 16'hFFFF)), pick_q16(),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                     items++;
                  end
                  default: ;
               endcase
               send_sample(pick_species(), pick_abundance(), k == len);
               items++;
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_setup();
      test_weighted_defaults();
      test_zero_total();
      test_ignored_items();
      test_linear_mode();
      test_load_mid_sample();
      test_sum_saturation();
      test_random();
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run: %0d transfers in, %0d samples closed, %0d estimates checked, %0d mismatches",
               transfers_sent, samples_closed, estimates_checked, mismatches);
      $display("Exercised both modes, count clamps, zero totals, saturation and mid-sample loads");
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
